// ===== hw/rtl/cbsp_pkg.sv =====
// Shared types and constants for the old binary cpio stream parser.
// No dependencies; cbsp_step, the parser top and the testbench import this package.
`default_nettype none

package cbsp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_FILE   = 3'd2,
    PH_LINK   = 3'd3,
    PH_DONE   = 3'd4,
    PH_POISON = 3'd5
  } phase_t;

  // Operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Byte classes
  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_NAME    = 3'd1;
  localparam logic [2:0] CLS_CONTENT = 3'd2;
  localparam logic [2:0] CLS_LINK    = 3'd3;
  localparam logic [2:0] CLS_PAD     = 3'd4;
  localparam logic [2:0] CLS_AFTER   = 3'd5;
  localparam logic [2:0] CLS_POISON  = 3'd6;
  localparam logic [2:0] CLS_RESTART = 3'd7;

  // Entry events
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_BAD_MAGIC = 4'd1;
  localparam logic [3:0] EV_OPEN      = 4'd2;
  localparam logic [3:0] EV_EMPTY     = 4'd3;
  localparam logic [3:0] EV_CLOSE     = 4'd4;
  localparam logic [3:0] EV_NODE      = 4'd5;
  localparam logic [3:0] EV_DIR       = 4'd6;
  localparam logic [3:0] EV_LINK_DONE = 4'd7;
  localparam logic [3:0] EV_SKIP      = 4'd8;
  localparam logic [3:0] EV_TRAILER   = 4'd9;

  // File type nibbles (mode bits 15..12)
  localparam logic [3:0] FT_LINK = 4'o12;
  localparam logic [3:0] FT_FILE = 4'o10;
  localparam logic [3:0] FT_SOCK = 4'o14;
  localparam logic [3:0] FT_FIFO = 4'o01;
  localparam logic [3:0] FT_BLK  = 4'o06;
  localparam logic [3:0] FT_CHR  = 4'o02;
  localparam logic [3:0] FT_DIR  = 4'o04;

  // Magic words as seen with the first byte in the high half
  localparam logic [15:0] MAGIC_NATIVE  = 16'h71c7;
  localparam logic [15:0] MAGIC_SWAPPED = 16'hc771;

  // Header layout: byte position of the second byte of each kept word
  localparam logic [4:0] HDR_LAST     = 5'd25;
  localparam logic [4:0] POS_MAGIC    = 5'd1;
  localparam logic [4:0] POS_MODE     = 5'd7;
  localparam logic [4:0] POS_RDEV     = 5'd15;
  localparam logic [4:0] POS_NAMESIZE = 5'd21;
  localparam logic [4:0] POS_FSIZE_HI = 5'd23;
  localparam logic [4:0] POS_FSIZE_LO = 5'd25;

  localparam logic [3:0]  TRAILER_LEN    = 4'd10;
  localparam logic [16:0] TRAILER_PADDED = 17'd10;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] count;
    logic        swap;
    logic [7:0]  pending;
    logic [15:0] mode;
    logic [15:0] rdev;
    logic [15:0] namesize;
    logic [31:0] filesize;
    logic [3:0]  tpos;
    logic        tstill;
    logic        odd_pad;
    logic        magic_ok;
  } state_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] byte_value;
    logic [3:0] entry_event;
    logic       last;
  } result_t;

  function automatic state_t state_reset();
    state_t s;
    s          = '0;
    s.phase    = PH_HEADER;
    s.tstill   = 1'b1;
    return s;
  endfunction

  // "TRAILER!!!" followed by its terminating null
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54; // T
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h41; // A
      4'd3:    c = 8'h49; // I
      4'd4:    c = 8'h4c; // L
      4'd5:    c = 8'h45; // E
      4'd6:    c = 8'h52; // R
      4'd7:    c = 8'h21; // !
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbsp_if.sv =====
// Valid/ready channel interfaces for the cpio stream parser.
// Depends on nothing; payload widths are fixed by the word formats.
`default_nettype none

interface cbsp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface cbsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [7:0]  byte_value;
  logic [3:0]  entry_event;
  logic [3:0]  entry_type;
  logic [15:0] entry_mode;
  logic [15:0] entry_rdev;
  logic [31:0] entry_size;
  logic [15:0] name_length;
  logic        section_last;
  logic        finished;

  modport source (output valid, output byte_class, output byte_value, output entry_event,
                  output entry_type, output entry_mode, output entry_rdev,
                  output entry_size, output name_length, output section_last,
                  output finished, input ready);
  modport sink   (input valid, input byte_class, input byte_value, input entry_event,
                  input entry_type, input entry_mode, input entry_rdev,
                  input entry_size, input name_length, input section_last,
                  input finished, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cbsp_step.sv =====
// Per-byte parser step: next parser state and the tag for one archive word.
// Combinational; uses cbsp_pkg.
`default_nettype none

module cbsp_step (
  input  var cbsp_pkg::state_t  st,
  input  var logic              operation,
  input  var logic [7:0]        data_byte,
  output var cbsp_pkg::state_t  st_next,
  output var cbsp_pkg::result_t res
);
  import cbsp_pkg::*;

  state_t      upd;
  logic [15:0] word;
  logic [16:0] padded;
  logic        restart;
  logic        hdr_end;
  logic        name_end;
  logic        body_final;
  logic        eon_trailer;
  phase_t      eon_phase;
  logic [3:0]  eon_event;

  assign restart = (operation == OP_RESTART);
  assign word    = st.swap ? {data_byte, st.pending} : {st.pending, data_byte};
  assign padded  = (17'(st.namesize) + 17'd1) & ~17'd1;

  assign hdr_end    = (st.phase == PH_HEADER) && (st.count >= 32'(HDR_LAST));
  assign name_end   = (st.phase == PH_NAME) &&
                      ((33'(st.count) + 33'd1) >= 33'(padded));
  assign body_final = st.odd_pad ? (st.count >= st.filesize)
                                 : ((33'(st.count) + 33'd1) >= 33'(st.filesize));

  // Restart, header fields and trailer match
  always_comb begin
    upd = st;
    if (restart) begin
      upd = state_reset();
    end else begin
      case (st.phase)
        PH_HEADER: begin
          if (!st.count[0]) begin
            upd.pending = data_byte;
          end else if (st.count == 32'(POS_MAGIC)) begin
            upd.swap     = ({st.pending, data_byte} == MAGIC_SWAPPED);
            upd.magic_ok = ({st.pending, data_byte} == MAGIC_SWAPPED) ||
                           ({st.pending, data_byte} == MAGIC_NATIVE);
          end else if (st.count == 32'(POS_MODE)) begin
            upd.mode = word;
          end else if (st.count == 32'(POS_RDEV)) begin
            upd.rdev = word;
          end else if (st.count == 32'(POS_NAMESIZE)) begin
            upd.namesize = word;
          end else if (st.count == 32'(POS_FSIZE_HI)) begin
            upd.filesize[31:16] = word;
          end else if (st.count == 32'(POS_FSIZE_LO)) begin
            upd.filesize[15:0] = word;
          end
          if (hdr_end && upd.magic_ok) begin
            upd.tpos   = '0;
            upd.tstill = 1'b1;
          end
        end
        PH_NAME: begin
          if (st.tpos <= TRAILER_LEN && data_byte != trailer_char(st.tpos)) begin
            upd.tstill = 1'b0;
          end
          if (st.tpos <= TRAILER_LEN) begin
            upd.tpos = st.tpos + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // End of name: pick the entry event and where to go next
  always_comb begin
    eon_trailer = upd.tstill && (padded >= TRAILER_PADDED);
    eon_phase   = PH_HEADER;
    eon_event   = EV_SKIP;
    if (eon_trailer) begin
      eon_phase = PH_DONE;
      eon_event = EV_TRAILER;
    end else begin
      case (upd.mode[15:12])
        FT_LINK: begin
          eon_phase = (upd.filesize == '0) ? PH_HEADER : PH_LINK;
          eon_event = (upd.filesize == '0) ? EV_LINK_DONE : EV_NONE;
        end
        FT_FILE: begin
          eon_phase = (upd.filesize == '0) ? PH_HEADER : PH_FILE;
          eon_event = (upd.filesize == '0) ? EV_EMPTY : EV_OPEN;
        end
        FT_SOCK, FT_FIFO, FT_BLK, FT_CHR: eon_event = EV_NODE;
        FT_DIR:                           eon_event = EV_DIR;
        default:                          eon_event = EV_SKIP;
      endcase
    end
  end

  // Next phase, position and pad flag
  always_comb begin
    st_next = upd;
    if (!restart) begin
      unique case (st.phase)
        PH_HEADER: begin
          st_next.count = st.count + 32'd1;
          if (hdr_end) begin
            st_next.count = '0;
            if (!upd.magic_ok) begin
              st_next.phase = PH_POISON;
            end else if (upd.namesize == '0) begin
              st_next.phase = eon_phase;
              if (!eon_trailer) st_next.odd_pad = upd.filesize[0];
            end else begin
              st_next.phase = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          st_next.count = st.count + 32'd1;
          if (name_end) begin
            st_next.count = '0;
            st_next.phase = eon_phase;
            if (!eon_trailer) st_next.odd_pad = upd.filesize[0];
          end
        end
        PH_FILE, PH_LINK: begin
          st_next.count = st.count + 32'd1;
          if (body_final) begin
            st_next.count = '0;
            st_next.phase = PH_HEADER;
          end
        end
        PH_DONE: ;
        default: st_next.phase = PH_POISON;
      endcase
    end
  end

  // Tag for this word
  always_comb begin
    res.byte_class  = CLS_POISON;
    res.byte_value  = data_byte;
    res.entry_event = EV_NONE;
    res.last        = 1'b0;
    if (restart) begin
      res.byte_class = CLS_RESTART;
      res.byte_value = '0;
    end else begin
      unique case (st.phase)
        PH_HEADER: begin
          res.byte_class = CLS_HEADER;
          if (hdr_end) begin
            res.last = 1'b1;
            if (!upd.magic_ok)             res.entry_event = EV_BAD_MAGIC;
            else if (upd.namesize == '0)   res.entry_event = eon_event;
          end
        end
        PH_NAME: begin
          res.byte_class = (st.count < 32'(st.namesize)) ? CLS_NAME : CLS_PAD;
          if (name_end) begin
            res.last        = 1'b1;
            res.entry_event = eon_event;
          end
        end
        PH_FILE, PH_LINK: begin
          if (st.count >= st.filesize)  res.byte_class = CLS_PAD;
          else if (st.phase == PH_FILE) res.byte_class = CLS_CONTENT;
          else                          res.byte_class = CLS_LINK;
          if (body_final) begin
            res.last        = 1'b1;
            res.entry_event = (st.phase == PH_FILE) ? EV_CLOSE : EV_LINK_DONE;
          end
        end
        PH_DONE: res.byte_class = CLS_AFTER;
        default: res.byte_class = CLS_POISON;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpio_binary_stream_parser.sv =====
// Old binary cpio stream parser: tags each archive word (one byte) as header,
// name, content, symlink target, pad, after-trailer, poison or restart and
// reports entry events at the end of a header, a name or a content section,
// with the mode, rdev, size and name length of the current header. A restart
// word (operation = 1) returns the parser to the start of a new header. The
// block takes one word per clock while the sink takes results and gives one
// result per word: the accepting edge loads the input register, and the parser
// state update runs from it into the result register. A result held by the sink
// stalls the input. The throughput is set by the state update, which closes on
// itself every byte. Uses cbsp_pkg, cbsp_if and cbsp_step.
`default_nettype none

module cpio_binary_stream_parser (
  input var logic    clk,
  input var logic    rst,
  cbsp_in_if.sink    stream,
  cbsp_out_if.source result
);
  import cbsp_pkg::*;

  // Input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;

  // Parser state and result register
  state_t      st;
  state_t      st_next;
  result_t     res;
  logic        o_valid;
  result_t     o_res;
  logic [15:0] o_mode;
  logic [15:0] o_rdev;
  logic [31:0] o_size;
  logic [15:0] o_nsize;
  logic        o_finished;

  logic out_take;

  assign out_take     = !o_valid || result.ready;
  assign stream.ready = !s1_valid || out_take;

  cbsp_step u_step (
    .st        (st),
    .operation (s1_op),
    .data_byte (s1_byte),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      st       <= state_reset();
    end else begin
      if (stream.ready) s1_valid <= stream.valid;
      if (out_take) begin
        o_valid <= s1_valid;
        if (s1_valid) st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready) begin
      s1_op   <= stream.operation;
      s1_byte <= stream.data_byte;
    end
    if (out_take && s1_valid) begin
      o_res      <= res;
      o_mode     <= st_next.mode;
      o_rdev     <= st_next.rdev;
      o_size     <= st_next.filesize;
      o_nsize    <= st_next.namesize;
      o_finished <= (st_next.phase == PH_DONE);
    end
  end

  assign result.valid        = o_valid;
  assign result.byte_class   = o_res.byte_class;
  assign result.byte_value   = o_res.byte_value;
  assign result.entry_event  = o_res.entry_event;
  assign result.section_last = o_res.last;
  assign result.entry_type   = o_mode[15:12];
  assign result.entry_mode   = o_mode;
  assign result.entry_rdev   = o_rdev;
  assign result.entry_size   = o_size;
  assign result.name_length  = o_nsize;
  assign result.finished     = o_finished;

`ifndef ASSERT_OFF
  // Events only ever fire on the closing word of a section
  a_event_on_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.entry_event != EV_NONE |-> o_res.last)
    else $error("entry event without section end");

  // Finished is reached only through the trailer or while already past it
  a_finished_src: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_finished |->
      o_res.entry_event == EV_TRAILER || o_res.byte_class == CLS_AFTER)
    else $error("finished without trailer");

  // Bad magic leaves the parser poisoned
  a_bad_magic_poison: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.entry_event == EV_BAD_MAGIC |-> st.phase == PH_POISON)
    else $error("bad magic did not poison parser");

  // Restart clears the header fields
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.byte_class == CLS_RESTART |->
      o_mode == '0 && o_size == '0 && !o_finished && o_res.entry_event == EV_NONE)
    else $error("restart left header state");

  // Header position stays inside the 26-byte header
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_HEADER |-> st.count <= 32'(HDR_LAST))
    else $error("header position overrun");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_cpio_binary_stream_parser.sv =====
// Testbench for cpio_binary_stream_parser: feeds generated old-binary cpio archives
// (good, cut short, bad magic, trailer) and checks every tagged byte against a predictor.
// Depends on cbsp_pkg, cbsp_if and the parser RTL.
`timescale 1ns / 100ps

import cbsp_pkg::*;

typedef struct packed {
  logic [2:0]  byte_class;
  logic [7:0]  byte_value;
  logic [3:0]  entry_event;
  logic [3:0]  entry_type;
  logic [15:0] entry_mode;
  logic [15:0] entry_rdev;
  logic [31:0] entry_size;
  logic [15:0] name_length;
  logic        section_last;
  logic        finished;
} tag_t;

typedef enum int {NAME_RANDOM, NAME_TRAILER, NAME_NEAR} name_kind_t;

class cpio_tag_tracker;
  phase_t      phase;
  logic [31:0] sect_pos;
  logic        swapped;
  logic        magic_good;
  logic        pad_odd;
  logic        name_match;
  logic [7:0]  held;
  logic [15:0] mode;
  logic [15:0] rdev;
  logic [15:0] nsize;
  logic [31:0] fsize;
  logic [3:0]  match_pos;
  tag_t        tags_due[$];
  int          bad_tags = 0;
  int          words_in = 0;
  int          tags_seen = 0;
  int          events_seen = 0;
  int          trailers_seen = 0;
  int          bad_magic_seen = 0;
  int          restarts_seen = 0;

  function new();
    clear();
  endfunction

  static function logic [7:0] trailer_char(input int idx);
    logic [79:0] txt;
    txt = "TRAILER!!!";
    return txt[79 - 8*idx -: 8];
  endfunction

  function void clear();
    phase      = PH_HEADER;
    sect_pos   = '0;
    swapped    = 1'b0;
    magic_good = 1'b0;
    pad_odd    = 1'b0;
    name_match = 1'b1;
    held       = '0;
    mode       = '0;
    rdev       = '0;
    nsize      = '0;
    fsize      = '0;
    match_pos  = '0;
  endfunction

  // name done: pick the entry event and where the stream goes next
  function logic [3:0] close_name();
    logic [31:0] padded;
    logic [3:0]  ev;
    padded   = ({16'd0, nsize} + 32'd1) & ~32'd1;
    sect_pos = '0;
    phase    = PH_HEADER;
    if (name_match && padded >= 32'd10) begin
      phase = PH_DONE;
      return EV_TRAILER;
    end
    pad_odd = fsize[0];
    case (mode[15:12])
      FT_LINK: begin
        ev = (fsize == 0) ? EV_LINK_DONE : EV_NONE;
        if (fsize != 0) phase = PH_LINK;
      end
      FT_FILE: begin
        ev = (fsize == 0) ? EV_EMPTY : EV_OPEN;
        if (fsize != 0) phase = PH_FILE;
      end
      FT_SOCK, FT_FIFO, FT_BLK, FT_CHR: ev = EV_NODE;
      FT_DIR: ev = EV_DIR;
      default: ev = EV_SKIP;
    endcase
    return ev;
  endfunction

  function void take_byte(input logic op, input logic [7:0] b);
    tag_t        t;
    logic [31:0] pos;
    logic [31:0] padded;
    logic [15:0] w;
    logic        final_byte;
    t = '0;
    t.byte_value = b;
    pos = sect_pos;
    words_in++;
    if (op == OP_RESTART) begin
      clear();
      t.byte_class = CLS_RESTART;
      t.byte_value = '0;
      restarts_seen++;
    end else begin
      case (phase)
        PH_HEADER: begin
          t.byte_class = CLS_HEADER;
          w = swapped ? {b, held} : {held, b};
          if (!pos[0]) begin
            held = b;
          end else if (pos == POS_MAGIC) begin
            magic_good = ({held, b} == MAGIC_NATIVE) || ({held, b} == MAGIC_SWAPPED);
            swapped    = ({held, b} == MAGIC_SWAPPED);
          end else if (pos == POS_MODE) begin
            mode = w;
          end else if (pos == POS_RDEV) begin
            rdev = w;
          end else if (pos == POS_NAMESIZE) begin
            nsize = w;
          end else if (pos == POS_FSIZE_HI) begin
            fsize[31:16] = w;
          end else if (pos == POS_FSIZE_LO) begin
            fsize[15:0] = w;
          end
          sect_pos = pos + 32'd1;
          if (pos >= HDR_LAST) begin
            t.section_last = 1'b1;
            sect_pos = '0;
            if (!magic_good) begin
              phase = PH_POISON;
              t.entry_event = EV_BAD_MAGIC;
            end else begin
              phase = PH_NAME;
              match_pos = '0;
              name_match = 1'b1;
              if (nsize == 0) t.entry_event = close_name();
            end
          end
        end
        PH_NAME: begin
          padded = ({16'd0, nsize} + 32'd1) & ~32'd1;
          t.byte_class = (pos < nsize) ? CLS_NAME : CLS_PAD;
          if (match_pos < 4'd10) begin
            if (b != trailer_char(match_pos)) name_match = 1'b0;
          end else if (match_pos == 4'd10 && b != 8'h00) begin
            name_match = 1'b0;
          end
          if (match_pos < 4'd11) match_pos++;
          sect_pos = pos + 32'd1;
          if (pos + 32'd1 >= padded) begin
            t.section_last = 1'b1;
            t.entry_event = close_name();
          end
        end
        PH_FILE, PH_LINK: begin
          final_byte = pad_odd ? (pos >= fsize) : (pos + 32'd1 >= fsize);
          t.byte_class = (pos < fsize) ? ((phase == PH_FILE) ? CLS_CONTENT : CLS_LINK)
                                       : CLS_PAD;
          sect_pos = pos + 32'd1;
          if (final_byte) begin
            t.section_last = 1'b1;
            t.entry_event = (phase == PH_FILE) ? EV_CLOSE : EV_LINK_DONE;
            phase = PH_HEADER;
            sect_pos = '0;
          end
        end
        PH_DONE: t.byte_class = CLS_AFTER;
        default: begin
          phase = PH_POISON;
          t.byte_class = CLS_POISON;
        end
      endcase
    end
    t.entry_type  = mode[15:12];
    t.entry_mode  = mode;
    t.entry_rdev  = rdev;
    t.entry_size  = fsize;
    t.name_length = nsize;
    t.finished    = (phase == PH_DONE);
    if (t.entry_event != EV_NONE) events_seen++;
    if (t.entry_event == EV_TRAILER) trailers_seen++;
    if (t.entry_event == EV_BAD_MAGIC) bad_magic_seen++;
    tags_due.push_back(t);
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      bad_tags++;
      if (bad_tags <= 20)
        $display("%0t: result %0d %s expected %h, got %h", $time, tags_seen, name, want, got);
    end
  endfunction

  function void match_tag(input tag_t got);
    tag_t want;
    if (tags_due.size() == 0) begin
      bad_tags++;
      if (bad_tags <= 20)
        $display("%0t: result %h arrived with nothing expected", $time, got);
      return;
    end
    want = tags_due.pop_front();
    tags_seen++;
    check_field("byte_class", want.byte_class, got.byte_class);
    check_field("byte_value", want.byte_value, got.byte_value);
    check_field("entry_event", want.entry_event, got.entry_event);
    check_field("entry_type", want.entry_type, got.entry_type);
    check_field("entry_mode", want.entry_mode, got.entry_mode);
    check_field("entry_rdev", want.entry_rdev, got.entry_rdev);
    check_field("entry_size", want.entry_size, got.entry_size);
    check_field("name_length", want.name_length, got.name_length);
    check_field("section_last", want.section_last, got.section_last);
    check_field("finished", want.finished, got.finished);
  endfunction

  function int pending();
    return tags_due.size();
  endfunction

  function void finish_check();
    if (tags_due.size() != 0) begin
      bad_tags += tags_due.size();
      $display("%0t: %0d expected results never arrived", $time, tags_due.size());
    end
  endfunction
endclass

module tb_cpio_binary_stream_parser;
  localparam int RANDOM_WORDS = 300;  // per traffic phase

  logic clk;
  logic rst;

  cbsp_in_if  word_in ();
  cbsp_out_if tag_out ();

  cpio_binary_stream_parser uut (
    .clk    (clk),
    .rst    (rst),
    .stream (word_in),
    .result (tag_out)
  );

  cpio_tag_tracker tracker = new();
  logic [8:0]  words_q[$];  // {operation, data_byte}
  int unsigned send_idle = 12;
  int unsigned recv_stall = 81;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: parser stopped moving words");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void put_byte(input logic [7:0] b);
    words_q.push_back({OP_BYTE, b});
  endfunction

  function automatic void put_restart();
    words_q.push_back({OP_RESTART, 8'($urandom)});
  endfunction

  // One archive entry: header, padded name, padded content for files and links.
  // cut >= 0 stops the entry after that many bytes and follows it with a restart.
  function automatic void add_entry(input logic swap_order, input logic [15:0] magic,
                                    input logic [15:0] mode, input logic [31:0] fsize,
                                    input logic [15:0] nsize, input name_kind_t kind,
                                    input int cut);
    logic [15:0] hw[13];
    logic [7:0]  e[$];
    logic [7:0]  nb;
    logic        restart_after;
    int          padded;
    int          body;
    int          miss_at;
    int          stop;
    int          k;
    restart_after = (cut >= 0);
    for (k = 0; k < 13; k++) hw[k] = 16'($urandom);
    hw[0]  = magic;
    hw[3]  = mode;
    hw[10] = nsize;
    hw[11] = fsize[31:16];
    hw[12] = fsize[15:0];
    for (k = 0; k < 13; k++) begin
      if (swap_order) begin
        e.push_back(hw[k][7:0]);
        e.push_back(hw[k][15:8]);
      end else begin
        e.push_back(hw[k][15:8]);
        e.push_back(hw[k][7:0]);
      end
    end
    padded = (int'(nsize) + 1) & ~1;
    if (padded > 1000) begin
      // huge name: send a slice of it, then restart
      padded = 20;
      restart_after = 1'b1;
    end
    miss_at = (padded > 0) ? $urandom_range(((padded < 11) ? padded : 11) - 1, 0) : 0;
    for (k = 0; k < padded; k++) begin
      nb = 8'($urandom);
      if (kind != NAME_RANDOM) begin
        if (k < 10) nb = cbsp_pkg::trailer_char(4'(k));
        else if (k == 10) nb = 8'h00;
      end
      if (kind == NAME_NEAR && k == miss_at) nb ^= 8'($urandom_range(255, 1));
      e.push_back(nb);
    end
    if (kind != NAME_TRAILER && (mode[15:12] == FT_FILE || mode[15:12] == FT_LINK)) begin
      if (fsize < 64) begin
        body = (int'(fsize) + 1) & ~1;
      end else begin
        body = $urandom_range(30, 1);
        restart_after = 1'b1;
      end
      repeat (body) e.push_back(8'($urandom));
    end
    stop = (cut >= 0 && cut < e.size()) ? cut : e.size();
    for (k = 0; k < stop; k++) put_byte(e[k]);
    if (restart_after) put_restart();
  endfunction

  // A few entries, then either a trailer or an early break (bad magic, cut entry).
  function automatic void add_archive();
    logic        swap_order;
    logic [3:0]  ftype;
    logic [31:0] fsize;
    logic [15:0] nsize;
    logic        has_body;
    name_kind_t  kind;
    int          entries;
    int          pick;
    int          k;
    swap_order = 1'($urandom);
    entries = $urandom_range(4, 1);
    for (k = 0; k < entries; k++) begin
      if ($urandom_range(9) == 0) swap_order = ~swap_order;
      pick = $urandom_range(15);
      case (pick)
        0, 1, 2, 3: ftype = FT_FILE;
        4, 5:       ftype = FT_LINK;
        6:          ftype = FT_SOCK;
        7:          ftype = FT_FIFO;
        8:          ftype = FT_BLK;
        9:          ftype = FT_CHR;
        10, 11:     ftype = FT_DIR;
        default:    ftype = 4'($urandom);
      endcase
      has_body = (ftype == FT_FILE || ftype == FT_LINK);
      pick = $urandom_range(99);
      if (!has_body) fsize = $urandom;
      else if (pick < 10) fsize = '0;
      else if (pick < 90) fsize = $urandom_range(13, 1);
      else fsize = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) nsize = '0;
      else if (pick < 80) nsize = 16'($urandom_range(14, 1));
      else if (pick < 95) nsize = 16'($urandom_range(60, 15));
      else if (pick < 98) nsize = 16'($urandom_range(400, 200));
      else nsize = 16'hffff - 16'($urandom_range(3));
      kind = ($urandom_range(19) == 0 && nsize >= 8) ? NAME_NEAR : NAME_RANDOM;
      pick = $urandom_range(99);
      if (pick < 4) begin
        // bad magic poisons everything up to the restart
        add_entry(swap_order, 16'($urandom), {ftype, 12'($urandom)}, fsize, nsize, kind,
                  $urandom_range(40, 26));
        return;
      end
      if (pick < 10 || nsize > 1000 || (has_body && fsize >= 64)) begin
        add_entry(swap_order, MAGIC_NATIVE, {ftype, 12'($urandom)}, fsize, nsize, kind,
                  (pick < 10) ? $urandom_range(60, 0) : 100000);
        return;
      end
      add_entry(swap_order, MAGIC_NATIVE, {ftype, 12'($urandom)}, fsize, nsize, kind, -1);
    end
    nsize = 16'($urandom_range(14, 8));
    add_entry(swap_order, MAGIC_NATIVE, 16'($urandom), $urandom, nsize, NAME_TRAILER, -1);
    repeat ($urandom_range(4)) put_byte(8'($urandom));
    put_restart();
  endfunction

  task automatic send_words();
    logic [8:0] w;
    while (words_q.size() != 0) begin
      if ($urandom_range(99) < send_idle) begin
        word_in.valid <= 1'b0;
        @(posedge clk);
      end else begin
        w = words_q.pop_front();
        word_in.valid     <= 1'b1;
        word_in.operation <= w[8];
        word_in.data_byte <= w[7:0];
        @(posedge clk);
        while (word_in.ready !== 1'b1) @(posedge clk);
        tracker.take_byte(w[8], w[7:0]);
      end
    end
    word_in.valid <= 1'b0;
  endtask

  initial begin
    tag_t got;
    tag_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tag_out.valid === 1'b1 && tag_out.ready === 1'b1) begin
        got = {tag_out.byte_class, tag_out.byte_value, tag_out.entry_event,
               tag_out.entry_type, tag_out.entry_mode, tag_out.entry_rdev,
               tag_out.entry_size, tag_out.name_length, tag_out.section_last,
               tag_out.finished};
        tracker.match_tag(got);
      end
      tag_out.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    int waited;
    int phase_no;
    rst               <= 1'b1;
    word_in.valid     <= 1'b0;
    word_in.operation <= OP_BYTE;
    word_in.data_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // restart straight out of reset, bad magic with all-ones fields, swapped magic
    // with an empty name and empty file, zero-length symlink, trailer whose pad is '!'
    put_restart();
    add_entry(1'b0, 16'h0000, 16'hffff, 32'hffff_ffff, 16'hffff, NAME_RANDOM, 30);
    add_entry(1'b1, MAGIC_NATIVE, {FT_FILE, 12'o644}, '0, '0, NAME_RANDOM, -1);
    add_entry(1'b0, MAGIC_NATIVE, {FT_LINK, 12'o777}, '0, 16'd3, NAME_RANDOM, -1);
    add_entry(1'b0, MAGIC_NATIVE, {FT_DIR, 12'o755}, 32'h1234_5678, 16'd9, NAME_TRAILER, -1);
    put_byte(8'hff);
    put_byte(8'h00);
    put_restart();

    for (phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle  = (phase_no == 0) ? 12 : (phase_no == 1) ? 81 : 0;
      recv_stall = (phase_no == 0) ? 81 : (phase_no == 1) ? 12 : 0;
      while (words_q.size() < RANDOM_WORDS) add_archive();
      send_words();
      waited = 0;
      do begin
        @(posedge clk);
        waited++;
      end while (tracker.pending() != 0 && waited < 100000);
    end
    repeat (10) @(posedge clk);
    tracker.finish_check();

    $display("Run covered %0d input words (%0d restarts) and %0d checked results.",
             tracker.words_in, tracker.restarts_seen, tracker.tags_seen);
    $display("Entry events seen: %0d, including %0d trailers and %0d bad magic headers.",
             tracker.events_seen, tracker.trailers_seen, tracker.bad_magic_seen);
    if (tracker.bad_tags == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
